/* hdl/mqrf_pkg.sv */
package mqrf_pkg;

  localparam int QD_BITS   = 7;
  localparam int QIDX_BITS = 3;
  localparam logic [QD_BITS-1:0] QD_RESET = 7'd64;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fin;
  } cmd_t;

endpackage

/* hdl/mqrf_ctrl.sv */
module mqrf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output mqrf_pkg::cmd_t cmd
);
  import mqrf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_READ;
      S_READ:  state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_READ:  cmd.fin = 1'b1;
      S_DONE:  done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

/* hdl/mqrf_dp.sv */
module mqrf_dp #(
  parameter int NUM_QUEUES = 8,
  parameter int MAX_DEPTH  = 64,
  parameter int WORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mqrf_pkg::cmd_t                 cmd,
  input  logic                           cfg_write,
  input  logic [mqrf_pkg::QD_BITS-1:0]   cfg_data,
  input  logic                           req_type,
  input  logic [mqrf_pkg::QIDX_BITS-1:0] queue_index,
  input  logic [WORD_BITS-1:0]           task_word,
  output logic [WORD_BITS-1:0]           task_out,
  output logic [1:0]                     status
);
  import mqrf_pkg::*;

  localparam int PW    = $clog2(MAX_DEPTH);
  localparam int DW    = $clog2(MAX_DEPTH + 1);
  localparam int CW    = (DW > QD_BITS) ? DW : QD_BITS;
  localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int AW    = $clog2(NUM_QUEUES * MAX_DEPTH);
  localparam int NQW   = $clog2(NUM_QUEUES + 1) + QIDX_BITS;

  logic [QD_BITS-1:0]   queue_depth;
  logic                 req_kind;
  logic [QIDX_BITS-1:0] req_q;
  logic [WORD_BITS-1:0] req_word;

  logic [PW-1:0] rd_ptr [NUM_QUEUES];
  logic [PW-1:0] wr_ptr [NUM_QUEUES];
  logic [DW-1:0] fill   [NUM_QUEUES];

  logic [WORD_BITS-1:0] mem [NUM_QUEUES * MAX_DEPTH];
  logic [WORD_BITS-1:0] rdata;
  logic                 deq_ok;

  logic [QIW-1:0] qi;
  logic           absent;
  logic [CW-1:0]  qd_ext;
  logic [CW-1:0]  depth;
  logic [DW-1:0]  cur_fill;
  logic           is_full;
  logic           is_empty;
  logic           do_enq;
  logic           do_deq;
  logic [PW-1:0]  rd_raw;
  logic [PW-1:0]  wr_raw;
  logic [PW-1:0]  rd_slot;
  logic [PW-1:0]  wr_slot;
  logic [PW:0]    rd_inc;
  logic [PW:0]    wr_inc;
  logic [PW-1:0]  rd_adv;
  logic [PW-1:0]  wr_adv;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [1:0]     status_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_depth <= QD_RESET;
    end else if (cfg_write) begin
      queue_depth <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= req_type;
      req_q    <= queue_index;
      req_word <= task_word;
    end
  end

  always_comb begin
    qi       = QIW'(req_q);
    absent   = NQW'(req_q) >= NQW'(NUM_QUEUES);
    qd_ext   = CW'(queue_depth);
    if (queue_depth == '0) begin
      depth = CW'(1);
    end else if (qd_ext > CW'(MAX_DEPTH)) begin
      depth = CW'(MAX_DEPTH);
    end else begin
      depth = qd_ext;
    end
    cur_fill = fill[qi];
    is_full  = CW'(cur_fill) >= depth;
    is_empty = cur_fill == '0;
    do_enq   = !absent && (req_kind == REQ_ENQ) && !is_full;
    do_deq   = !absent && (req_kind == REQ_DEQ) && !is_empty;

    rd_raw  = rd_ptr[qi];
    wr_raw  = wr_ptr[qi];
    rd_slot = ({1'b0, rd_raw} >= (PW+1)'(MAX_DEPTH)) ? '0 : rd_raw;
    wr_slot = ({1'b0, wr_raw} >= (PW+1)'(MAX_DEPTH)) ? '0 : wr_raw;
    rd_inc  = {1'b0, rd_slot} + (PW+1)'(1);
    wr_inc  = {1'b0, wr_slot} + (PW+1)'(1);
    rd_adv  = (CW'(rd_inc) >= depth) ? '0 : PW'(rd_inc);
    wr_adv  = (CW'(wr_inc) >= depth) ? '0 : PW'(wr_inc);
    rd_addr = AW'(qi) * AW'(MAX_DEPTH) + AW'(rd_slot);
    wr_addr = AW'(qi) * AW'(MAX_DEPTH) + AW'(wr_slot);

    if (do_enq || do_deq) begin
      status_calc = ST_OK;
    end else if (req_kind == REQ_ENQ) begin
      status_calc = ST_FULL;
    end else begin
      status_calc = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else if (cmd.exec) begin
      if (do_enq) begin
        wr_ptr[qi] <= wr_adv;
        fill[qi]   <= cur_fill + DW'(1);
      end
      if (do_deq) begin
        rd_ptr[qi] <= rd_adv;
        fill[qi]   <= cur_fill - DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_enq) begin
        mem[wr_addr] <= req_word;
      end
      rdata  <= mem[rd_addr];
      deq_ok <= do_deq;
      status <= status_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      task_out <= deq_ok ? rdata : '0;
    end
  end

endmodule

/* hdl/multi_queue_ring_fifo.sv */
// Holds NUM_QUEUES independent ring FIFOs of task words in one shared entry memory.
// A request is taken when start is high and busy is low; busy then stays high
// until the answer has been given. A request passes through four steps from start to
// the done strobe: capture of the request, execution against the queue
// pointers with the memory read into a register, forming of the result, and
// presenting it. A new request can be taken in the cycle after done.
// task_out and status are valid only while done is high, for that single cycle;
// the receiver cannot stall and must take the transaction then. queue_depth may
// be written through cfg_valid/cfg_ready only while busy is low.
module multi_queue_ring_fifo #(
  parameter int NUM_QUEUES = 8,
  parameter int MAX_DEPTH  = 64,
  parameter int WORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           req_type,
  input  logic [mqrf_pkg::QIDX_BITS-1:0] queue_index,
  input  logic [WORD_BITS-1:0]           task_word,
  output logic                           done,
  output logic [WORD_BITS-1:0]           task_out,
  output logic [1:0]                     status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mqrf_pkg::QD_BITS-1:0]   cfg_data
);
  import mqrf_pkg::*;

  cmd_t cmd;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  mqrf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  mqrf_dp #(
    .NUM_QUEUES (NUM_QUEUES),
    .MAX_DEPTH  (MAX_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .queue_index (queue_index),
    .task_word   (task_word),
    .task_out    (task_out),
    .status      (status)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("busy held after result");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy && $past(busy))
    else $error("result outside a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("status code out of range");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> task_out == '0)
    else $error("task_out not zero on refused request");
`endif

endmodule

/* test/multi_queue_ring_fifo_tb.sv */
module multi_queue_ring_fifo_tb;
  import mqrf_pkg::*;

  localparam int QUEUES     = 8;
  localparam int RING_SLOTS = 64;
  localparam int WORD_W     = 32;

  typedef struct {
    logic              kind;
    logic [2:0]        qsel;
    logic [WORD_W-1:0] word;
  } fifo_req_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [1:0]        status;
  } fifo_ans_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type = REQ_ENQ;
  logic [2:0]        queue_index = '0;
  logic [WORD_W-1:0] task_word = '0;
  logic              done;
  logic [WORD_W-1:0] task_out;
  logic [1:0]        status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data = '0;

  fifo_req_t   req_q[$];
  fifo_ans_t   answer_q[$];
  int          idle_pct = 0;
  int          errors = 0;

  logic [6:0]        depth_reg = QD_RESET;
  int unsigned       rd_ptr [QUEUES];
  int unsigned       wr_ptr [QUEUES];
  int unsigned       fill   [QUEUES];
  logic [WORD_W-1:0] ring   [QUEUES][RING_SLOTS];

  multi_queue_ring_fifo dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .queue_index (queue_index),
    .task_word   (task_word),
    .done        (done),
    .task_out    (task_out),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    for (int q = 0; q < QUEUES; q++) begin
      rd_ptr[q] = 0;
      wr_ptr[q] = 0;
      fill[q]   = 0;
      for (int s = 0; s < RING_SLOTS; s++) ring[q][s] = '0;
    end
  end

  function automatic fifo_ans_t serve_request(fifo_req_t r);
    fifo_ans_t   a;
    int unsigned lim;
    int unsigned slot;
    lim = (depth_reg == 0) ? 1 : ((depth_reg > RING_SLOTS) ? RING_SLOTS : depth_reg);
    a.word   = '0;
    a.status = ST_OK;
    if (r.kind == REQ_ENQ) begin
      if (fill[r.qsel] >= lim) begin
        a.status = ST_FULL;
      end else begin
        slot = wr_ptr[r.qsel];
        ring[r.qsel][slot] = r.word;
        wr_ptr[r.qsel] = (slot + 1 >= lim) ? 0 : slot + 1;
        fill[r.qsel]++;
      end
    end else begin
      if (fill[r.qsel] == 0) begin
        a.status = ST_EMPTY;
      end else begin
        slot = rd_ptr[r.qsel];
        a.word = ring[r.qsel][slot];
        rd_ptr[r.qsel] = (slot + 1 >= lim) ? 0 : slot + 1;
        fill[r.qsel]--;
      end
    end
    return a;
  endfunction

  // hold the request until accepted, then pick the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) answer_q.push_back(serve_request(req_q.pop_front()));
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start       <= 1'b1;
        req_type    <= req_q[0].kind;
        queue_index <= req_q[0].qsel;
        task_word   <= req_q[0].word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    fifo_ans_t e;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected transaction: task_out %h status %0d", task_out, status);
        errors++;
      end else begin
        e = answer_q.pop_front();
        if (task_out !== e.word || status !== e.status) begin
          if (errors < 10)
            $display("mismatch: task_out %h (exp %h) status %0d (exp %0d)",
                     task_out, e.word, status, e.status);
          errors++;
        end
      end
    end
  end

  task automatic push_req(input logic kind, input logic [2:0] q, input logic [WORD_W-1:0] w);
    fifo_req_t r;
    r.kind = kind;
    r.qsel = q;
    r.word = w;
    req_q.push_back(r);
  endtask

  task automatic settle();
    while (req_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_depth(input logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    depth_reg = v;
    cfg_valid <= 1'b0;
  endtask

  // spread requests of one kind over all queues, each queue getting per_q of them
  task automatic scatter(input logic kind, input int per_q);
    int left [QUEUES];
    int q;
    for (int i = 0; i < QUEUES; i++) left[i] = per_q;
    repeat (QUEUES * per_q) begin
      do q = $urandom_range(QUEUES - 1); while (left[q] == 0);
      left[q]--;
      push_req(kind, q[2:0], $urandom());
    end
  endtask

  initial begin
    logic [6:0] depth_plan [9];
    int         lead;
    int         p_enq;
    logic [2:0] q;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 0;
    push_req(REQ_DEQ, 3'd0, $urandom());
    push_req(REQ_ENQ, 3'd0, 32'h0000_0000);
    push_req(REQ_ENQ, 3'd0, 32'hFFFF_FFFF);
    push_req(REQ_ENQ, 3'd7, 32'hA5A5_A5A5);
    push_req(REQ_ENQ, 3'd7, 32'h5A5A_5A5A);
    push_req(REQ_ENQ, 3'd3, $urandom());
    push_req(REQ_DEQ, 3'd0, $urandom());
    push_req(REQ_DEQ, 3'd7, $urandom());
    push_req(REQ_DEQ, 3'd0, $urandom());
    push_req(REQ_DEQ, 3'd0, $urandom());
    push_req(REQ_DEQ, 3'd7, $urandom());
    push_req(REQ_DEQ, 3'd3, $urandom());
    push_req(REQ_DEQ, 3'd3, $urandom());
    push_req(REQ_DEQ, 3'd7, $urandom());
    settle();

    // fill every ring to the brim at full depth so each slot holds a written word
    idle_pct = 23;
    scatter(REQ_ENQ, RING_SLOTS + 1);
    settle();
    idle_pct = 51;
    scatter(REQ_DEQ, RING_SLOTS + 1);
    settle();

    depth_plan[0] = 7'd1;
    depth_plan[1] = 7'd0;
    depth_plan[2] = 7'd127;
    depth_plan[3] = 7'd2;
    depth_plan[4] = 7'($urandom_range(3, 63));
    depth_plan[5] = 7'd64;
    depth_plan[6] = 7'd63;
    depth_plan[7] = 7'($urandom_range(3, 16));
    depth_plan[8] = 7'd65;

    for (int ph = 0; ph < 9; ph++) begin
      settle();
      write_depth(depth_plan[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 51;
        default: idle_pct = 23;
      endcase
      p_enq = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 35 : 55);
      lead  = $urandom_range(QUEUES - 1);
      repeat (100) begin
        q = ($urandom_range(3) == 0) ? 3'($urandom_range(QUEUES - 1)) : 3'(lead);
        push_req(($urandom_range(99) < p_enq) ? REQ_ENQ : REQ_DEQ, q, $urandom());
      end
    end
    settle();

    if (errors == 0)
      $display("multi_queue_ring_fifo_tb: done, clean");
    else
      $display("multi_queue_ring_fifo_tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("multi_queue_ring_fifo_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hdl/mqrf_pkg.sv
hdl/mqrf_ctrl.sv
hdl/mqrf_dp.sv
hdl/multi_queue_ring_fifo.sv
test/multi_queue_ring_fifo_tb.sv
